/* rtl/tlbpt_pkg.sv */
package tlbpt_pkg;
  localparam int PAGE_OFFSET_BITS_DEF = 12;
  localparam int VIRT_PAGE_BITS_DEF = 20;
  localparam int FRAME_BITS_DEF = 18;
  localparam int TLB_ENTRIES_DEF = 16;
  localparam int ADDR_W = 32;
  localparam int PA_W = 30;
  localparam int CNT_W = 32;

  localparam logic [1:0] CMD_TRANSLATE = 2'd0;
  localparam logic [1:0] CMD_MAP = 2'd1;
  localparam logic [1:0] CMD_UNMAP = 2'd2;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_FAULT = 2'd1;
  localparam logic [1:0] ST_REFUSED = 2'd2;

  typedef struct packed {
    logic [1:0]        command;
    logic [ADDR_W-1:0] vaddr;
    logic [23:0]       frame_number;
  } tlbpt_cmd_t;
endpackage

/* rtl/tlbpt_front.sv */
module tlbpt_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  tlbpt_pkg::tlbpt_cmd_t in_cmd,
  output logic                  q_valid,
  input  logic                  q_pop,
  output tlbpt_pkg::tlbpt_cmd_t q_cmd
);
  import tlbpt_pkg::*;

  // two-entry queue between front and back
  tlbpt_cmd_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;

  assign in_stall = (cnt_r == 2'd2);
  assign push = in_valid && !in_stall;
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_cmd;
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule

/* rtl/tlbpt_back.sv */
module tlbpt_back #(
  parameter int PAGE_OFFSET_BITS = tlbpt_pkg::PAGE_OFFSET_BITS_DEF,
  parameter int VIRT_PAGE_BITS = tlbpt_pkg::VIRT_PAGE_BITS_DEF,
  parameter int FRAME_BITS = tlbpt_pkg::FRAME_BITS_DEF,
  parameter int TLB_ENTRIES = tlbpt_pkg::TLB_ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  output logic                  q_pop,
  input  tlbpt_pkg::tlbpt_cmd_t q_cmd,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_status,
  output logic                  out_tlb_hit,
  output logic [29:0]           out_physical_address,
  output logic [31:0]           out_lookup_count,
  output logic [31:0]           out_miss_count
);
  import tlbpt_pkg::*;

  localparam int PAGES = 1 << VIRT_PAGE_BITS;
  localparam int TW = $clog2(TLB_ENTRIES);
  localparam int PAW = FRAME_BITS + PAGE_OFFSET_BITS;

  typedef enum logic [1:0] {S_IDLE, S_LOOK, S_CLEAR} state_t;

  state_t state_r;
  logic [FRAME_BITS-1:0]     frames [PAGES];
  logic                      pvalid [PAGES];
  logic [VIRT_PAGE_BITS-1:0] tag_r [TLB_ENTRIES];
  logic [FRAME_BITS-1:0]     tfr_r [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0]    tv_r;
  logic [TW-1:0]             fp_r;
  logic [CNT_W-1:0]          lk_r, ms_r;
  logic [VIRT_PAGE_BITS:0]   clr_r;
  logic [1:0]                cmd_r;
  logic [VIRT_PAGE_BITS-1:0] vpn_r;
  logic [PAGE_OFFSET_BITS-1:0] off_r;
  logic [FRAME_BITS-1:0]     fin_r;
  logic [FRAME_BITS-1:0]     frd_r;
  logic                      vrd_r;
  logic [TLB_ENTRIES-1:0]    match;
  logic                      hit;
  logic [FRAME_BITS-1:0]     hfr;
  logic [VIRT_PAGE_BITS-1:0] qvpn;
  logic [PAW-1:0]            pa_full;
  logic [FRAME_BITS-1:0]     fr_sel;

  assign qvpn = q_cmd.vaddr[PAGE_OFFSET_BITS +: VIRT_PAGE_BITS];
  assign q_pop = (state_r == S_IDLE) && q_valid && !(out_valid && out_stall);

  always_comb begin
    hit = 1'b0;
    hfr = '0;
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      match[i] = tv_r[i] && (tag_r[i] == vpn_r);
      if (match[i] && !hit) begin
        hit = 1'b1;
        hfr = tfr_r[i];
      end
    end
  end

  assign fr_sel = hit ? hfr : frd_r;
  assign pa_full = {fr_sel, off_r};

  // page table ports
  always_ff @(posedge clk) begin
    frd_r <= frames[qvpn];
    vrd_r <= pvalid[qvpn];
    if (state_r == S_CLEAR) pvalid[clr_r[VIRT_PAGE_BITS-1:0]] <= 1'b0;
    else if (state_r == S_LOOK && cmd_r == CMD_MAP && !vrd_r) pvalid[vpn_r] <= 1'b1;
    else if (state_r == S_LOOK && cmd_r == CMD_UNMAP) pvalid[vpn_r] <= 1'b0;
    if (state_r == S_LOOK && cmd_r == CMD_MAP && !vrd_r)
      frames[vpn_r] <= fin_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      tv_r <= '0;
      fp_r <= '0;
      lk_r <= '0;
      ms_r <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == (VIRT_PAGE_BITS+1)'(PAGES - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (q_pop) begin
            cmd_r <= q_cmd.command;
            vpn_r <= qvpn;
            off_r <= q_cmd.vaddr[PAGE_OFFSET_BITS-1:0];
            fin_r <= q_cmd.frame_number[FRAME_BITS-1:0];
            state_r <= S_LOOK;
          end
        end
        S_LOOK: begin
          state_r <= S_IDLE;
          out_valid <= 1'b1;
          out_status <= ST_DONE;
          out_tlb_hit <= 1'b0;
          out_physical_address <= '0;
          out_lookup_count <= lk_r;
          out_miss_count <= ms_r;
          case (cmd_r)
            CMD_TRANSLATE: begin
              if (!vrd_r) out_status <= ST_FAULT;
              else begin
                out_tlb_hit <= hit;
                out_physical_address <= PA_W'({{PA_W{1'b0}}, pa_full});
                out_lookup_count <= lk_r + 1'b1;
                lk_r <= lk_r + 1'b1;
                if (!hit) begin
                  tag_r[fp_r] <= vpn_r;
                  tfr_r[fp_r] <= frd_r;
                  tv_r[fp_r] <= 1'b1;
                  fp_r <= (fp_r == TW'(TLB_ENTRIES - 1)) ? '0 : fp_r + 1'b1;
                  ms_r <= ms_r + 1'b1;
                  out_miss_count <= ms_r + 1'b1;
                end
              end
            end
            CMD_MAP: if (vrd_r) out_status <= ST_REFUSED;
            CMD_UNMAP: tv_r <= tv_r & ~match;
            default: ;
          endcase
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

/* rtl/tlb_page_table_translator.sv */
// Page translator: map, translate and unmap commands, one result beat per
// command. The back end reads the page table, then does the TLB compare,
// table update and TLB fill; it takes no new command until that is done.
// After reset the mapped bitmap is cleared one page per cycle over all
// 2^VIRT_PAGE_BITS pages, while commands queue but are not executed.
module tlb_page_table_translator #(
  parameter int PAGE_OFFSET_BITS = tlbpt_pkg::PAGE_OFFSET_BITS_DEF,
  parameter int VIRT_PAGE_BITS = tlbpt_pkg::VIRT_PAGE_BITS_DEF,
  parameter int FRAME_BITS = tlbpt_pkg::FRAME_BITS_DEF,
  parameter int TLB_ENTRIES = tlbpt_pkg::TLB_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_vaddr,
  input  logic [17:0] in_frame_number,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic        out_tlb_hit,
  output logic [29:0] out_physical_address,
  output logic [31:0] out_lookup_count,
  output logic [31:0] out_miss_count
);
  import tlbpt_pkg::*;

  tlbpt_cmd_t in_cmd, q_cmd;
  logic q_valid, q_pop;

  assign in_cmd.command = in_command;
  assign in_cmd.vaddr = in_vaddr;
  assign in_cmd.frame_number = {6'd0, in_frame_number};

  tlbpt_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_cmd,
    .q_valid, .q_pop, .q_cmd
  );

  tlbpt_back #(
    .PAGE_OFFSET_BITS(PAGE_OFFSET_BITS), .VIRT_PAGE_BITS(VIRT_PAGE_BITS),
    .FRAME_BITS(FRAME_BITS), .TLB_ENTRIES(TLB_ENTRIES)
  ) u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_cmd,
    .out_valid, .out_stall, .out_status, .out_tlb_hit,
    .out_physical_address, .out_lookup_count, .out_miss_count
  );
endmodule

/* test/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tlbpt_pkg::*;

  localparam int LIMIT = 4_000_000;
  localparam int RANDOM_BEATS = 550;
  localparam int PLAN_ROWS = 18;
  localparam int POOL = 24;

  typedef struct packed {
    logic [1:0]  status;
    logic        hit;
    logic [29:0] pa;
    logic [31:0] lookups;
    logic [31:0] misses;
  } xlate_t;

  typedef struct packed {
    bit          typed;
    logic [1:0]  cmd;
    logic [31:0] va;
    logic [17:0] frame;
    xlate_t      res;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_command = '0;
  logic [31:0] in_vaddr = '0;
  logic [17:0] in_frame_number = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic        out_tlb_hit;
  logic [29:0] out_physical_address;
  logic [31:0] out_lookup_count;
  logic [31:0] out_miss_count;

  // shadow of the translator state
  logic [17:0] frame_of [int];
  bit          mapped [int];
  logic [19:0] tlb_tag [16];
  logic [17:0] tlb_frm [16];
  bit          tlb_vld [16];
  logic [3:0]  fill_ptr = '0;
  logic [31:0] lookups = '0;
  logic [31:0] misses = '0;

  xlate_t      awaited_results [$];
  int          errors = 0;
  int          results_seen = 0;
  int          cycles = 0;
  bit          idle_on = 1'b1;
  bit          held = 1'b0;
  int          hold_left = 0;
  logic [19:0] vpn_pool [POOL];
  plan_row_t   plan [PLAN_ROWS];

  tlb_page_table_translator u_top (.*);

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("tlb_page_table_translator verification failed");
      $finish;
    end
  end

  function automatic xlate_t run_command(logic [1:0] cmd, logic [31:0] va, logic [17:0] fr);
    xlate_t r;
    int vpn;
    bit hit;
    logic [17:0] frm;
    vpn = int'(va[31:12]);
    r = '0;
    hit = 1'b0;
    frm = '0;
    if (cmd == CMD_TRANSLATE) begin
      if (!(mapped.exists(vpn) && mapped[vpn])) begin
        r.status = ST_FAULT;
      end else begin
        lookups = lookups + 32'd1;
        for (int i = 0; i < 16; i++)
          if (!hit && tlb_vld[i] && tlb_tag[i] == va[31:12]) begin
            hit = 1'b1;
            frm = tlb_frm[i];
          end
        if (!hit) begin
          frm = frame_of[vpn];
          tlb_tag[fill_ptr] = va[31:12];
          tlb_frm[fill_ptr] = frm;
          tlb_vld[fill_ptr] = 1'b1;
          fill_ptr = fill_ptr + 4'd1;
          misses = misses + 32'd1;
        end
        r.status = ST_DONE;
        r.hit = hit;
        r.pa = {frm, va[11:0]};
      end
    end else if (cmd == CMD_MAP) begin
      if (mapped.exists(vpn) && mapped[vpn]) begin
        r.status = ST_REFUSED;
      end else begin
        frame_of[vpn] = fr;
        mapped[vpn] = 1'b1;
        r.status = ST_DONE;
      end
    end else if (cmd == CMD_UNMAP) begin
      mapped[vpn] = 1'b0;
      for (int i = 0; i < 16; i++)
        if (tlb_vld[i] && tlb_tag[i] == va[31:12]) tlb_vld[i] = 1'b0;
      r.status = ST_DONE;
    end else begin
      r.status = ST_DONE;
    end
    r.lookups = lookups;
    r.misses = misses;
    return r;
  endfunction

  task automatic send_beat(logic [1:0] cmd, logic [31:0] va, logic [17:0] fr,
                           bit typed, xlate_t typed_res);
    xlate_t r;
    while (idle_on && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_vaddr <= va;
    in_frame_number <= fr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = run_command(cmd, va, fr);
    awaited_results.push_back(typed ? typed_res : r);
  endtask

  // receiver: random stall, one long hold-off, checking
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (awaited_results.size() == 0) begin
        $display("%0t unexpected beat: status %0d pa %h", $time, out_status,
                 out_physical_address);
        errors <= errors + 1;
      end else begin
        xlate_t e;
        e = awaited_results.pop_front();
        if (e !== {out_status, out_tlb_hit, out_physical_address, out_lookup_count,
                   out_miss_count}) begin
          $display("%0t mismatch: expected st %0d hit %0d pa %h lk %0d ms %0d", $time,
                   e.status, e.hit, e.pa, e.lookups, e.misses);
          $display("%0t           actual   st %0d hit %0d pa %h lk %0d ms %0d", $time,
                   out_status, out_tlb_hit, out_physical_address, out_lookup_count,
                   out_miss_count);
          errors <= errors + 1;
        end
      end
    end
    if (!held && results_seen == 120) begin
      held <= 1'b1;
      hold_left <= 400;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= idle_on && ($urandom_range(99) < 30);
    end
  end

  initial begin
    logic [1:0] cmd;
    logic [31:0] va;
    int pick;
    for (int i = 0; i < 16; i++) tlb_vld[i] = 1'b0;
    vpn_pool[0] = '0;
    vpn_pool[1] = '1;
    for (int i = 2; i < POOL; i++) vpn_pool[i] = 20'($urandom);
    plan = '{
      '{1'b1, CMD_TRANSLATE, 32'h0000_0000, 18'h0, '{ST_FAULT, 1'b0, 30'h0, 32'd0, 32'd0}},
      '{1'b1, CMD_MAP, 32'h0000_0000, 18'h3FFFF, '{ST_DONE, 1'b0, 30'h0, 32'd0, 32'd0}},
      '{1'b1, CMD_MAP, 32'h0000_0ABC, 18'h00001, '{ST_REFUSED, 1'b0, 30'h0, 32'd0, 32'd0}},
      '{1'b1, CMD_TRANSLATE, 32'h0000_0FFF, 18'h0,
        '{ST_DONE, 1'b0, 30'h3FFF_FFFF, 32'd1, 32'd1}},
      '{1'b1, CMD_TRANSLATE, 32'h0000_0000, 18'h0,
        '{ST_DONE, 1'b1, 30'h3FFF_F000, 32'd2, 32'd1}},
      '{1'b1, CMD_MAP, 32'hFFFF_F000, 18'h0, '{ST_DONE, 1'b0, 30'h0, 32'd2, 32'd1}},
      '{1'b1, CMD_TRANSLATE, 32'hFFFF_FFFF, 18'h0,
        '{ST_DONE, 1'b0, 30'h0000_0FFF, 32'd3, 32'd2}},
      '{1'b1, CMD_UNMAP, 32'h0000_0123, 18'h3FFFF, '{ST_DONE, 1'b0, 30'h0, 32'd3, 32'd2}},
      '{1'b1, CMD_TRANSLATE, 32'h0000_0001, 18'h0, '{ST_FAULT, 1'b0, 30'h0, 32'd3, 32'd2}},
      '{1'b1, CMD_UNMAP, 32'h0000_0000, 18'h0, '{ST_DONE, 1'b0, 30'h0, 32'd3, 32'd2}},
      '{1'b1, 2'd3, 32'hFFFF_FFFF, 18'h3FFFF, '{ST_DONE, 1'b0, 30'h0, 32'd3, 32'd2}},
      '{1'b0, CMD_MAP, 32'h1234_5678, 18'h2AAAA, '0},
      '{1'b0, CMD_TRANSLATE, 32'h1234_5A5A, 18'h0, '0},
      '{1'b0, CMD_MAP, 32'h0000_0000, 18'h15555, '0},
      '{1'b0, CMD_TRANSLATE, 32'h0000_0555, 18'h3FFFF, '0},
      '{1'b0, CMD_TRANSLATE, 32'h0000_0AAA, 18'h0, '0},
      '{1'b0, CMD_UNMAP, 32'hFFFF_F800, 18'h0, '0},
      '{1'b0, CMD_TRANSLATE, 32'hFFFF_F800, 18'h0, '0}
    };
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < PLAN_ROWS; i++)
      send_beat(plan[i].cmd, plan[i].va, plan[i].frame, plan[i].typed, plan[i].res);
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n == 300) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaited_results.size() != 0) @(posedge clk);
      end
      idle_on = !(n >= 400 && n < 480);
      pick = $urandom_range(99);
      if (pick < 50) cmd = CMD_TRANSLATE;
      else if (pick < 78) cmd = CMD_MAP;
      else if (pick < 94) cmd = CMD_UNMAP;
      else cmd = 2'd3;
      va = $urandom;
      if ($urandom_range(9) != 0) va[31:12] = vpn_pool[$urandom_range(POOL - 1)];
      send_beat(cmd, va, 18'($urandom), 1'b0, '0);
    end
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("tlb_page_table_translator verification clean");
    end else begin
      $display("tlb_page_table_translator verification failed");
    end
    $finish;
  end
endmodule
